// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; define ASSERT_OFF to drop them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Hold prop at every rising edge of clk outside reset.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// When cond holds at one edge, expect prop at the next.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: label");

`else

`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ===== sv/flptw_pkg.sv =====
// ----------------------------------------------------------------------------
// flptw_pkg
// Types, codes and masks for the four-level page table walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package flptw_pkg;

   // request kinds
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_ENTRY = 1'b1;

   // result kinds
   localparam logic RES_READ = 1'b0;
   localparam logic RES_DONE = 1'b1;

   localparam int IDX_W = 9;

   localparam logic [63:0] BASE_MASK  = 64'hFFFF_FFFF_FFFF_FFF0;
   localparam logic [63:0] TABLE_MASK = 64'h0000_000F_FFFF_F000;

   localparam int PRESENT_BIT = 0;
   localparam int LARGE_BIT   = 7;

   typedef enum logic [2:0] {
      LVL_IDLE = 3'd0,
      LVL_1    = 3'd1,
      LVL_2    = 3'd2,
      LVL_3    = 3'd3,
      LVL_4    = 3'd4
   } level_type;

   typedef struct packed {
      logic        req_type;
      logic [63:0] table_base;
      logic [47:0] virt_addr;
      logic [63:0] entry_word;
   } req_item_type;

   typedef struct packed {
      logic        res_kind;
      logic [63:0] read_addr;
      logic [51:0] phys_addr;
      logic        fault;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== sv/four_level_page_table_walker.sv =====
// An accepted item is decided from the input register and its result is
// registered in the two-entry result queue, whose head drives rsp_.
// Throughput: one item per cycle while the queue has room; the decision is at
// most one add after the input register; the queue absorbs a stalled consumer.
// Reset: synchronous, active high; clears the walk level and all valid flags.
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Walks four levels of 64-bit table entries for one 48-bit virtual address,
// issuing entry reads and finishing with a translation or a fault.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module four_level_page_table_walker (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  flptw_pkg::req_item_type   req_item,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output flptw_pkg::rsp_item_type   rsp_item
);

   import flptw_pkg::*;

   // input register
   logic          in_valid_ff;
   logic          in_valid_in;
   req_item_type  in_item_ff;

   // walk state
   level_type     walk_level_ff;
   level_type     walk_level_in;
   logic [47:0]   saved_vaddr_ff;
   logic [47:0]   saved_vaddr_in;

   // two-entry result queue, entry 0 is the head
   logic          q_valid_ff [2];
   logic          q_valid_in [2];
   rsp_item_type  q_item_ff  [2];
   rsp_item_type  q_item_in  [2];

   rsp_item_type  result;
   logic          has_result;
   logic          advance;
   logic          pop;
   logic          push;
   logic          accept;
   logic [IDX_W-1:0] next_idx;
   logic [63:0]   table_addr;

   // Decide the item in the input register against the current walk state.
   always_comb begin
      result         = '0;
      has_result     = 1'b0;
      walk_level_in  = walk_level_ff;
      saved_vaddr_in = saved_vaddr_ff;
      table_addr     = in_item_ff.entry_word & TABLE_MASK;
      next_idx       = '0;

      case (walk_level_ff)
         LVL_1:   next_idx = saved_vaddr_ff[38:30];
         LVL_2:   next_idx = saved_vaddr_ff[29:21];
         LVL_3:   next_idx = saved_vaddr_ff[20:12];
         default: next_idx = '0;
      endcase

      if (in_item_ff.req_type == REQ_START) begin
         // a start drops any walk in progress
         has_result       = 1'b1;
         saved_vaddr_in   = in_item_ff.virt_addr;
         walk_level_in    = LVL_1;
         result.res_kind  = RES_READ;
         result.read_addr = (in_item_ff.table_base & BASE_MASK)
                          + {52'd0, in_item_ff.virt_addr[47:39], 3'b000};
      end else begin
         case (walk_level_ff)
            LVL_1, LVL_2, LVL_3: begin
               has_result = 1'b1;
               if (!in_item_ff.entry_word[PRESENT_BIT]) begin
                  result.res_kind = RES_DONE;
                  result.fault    = 1'b1;
                  walk_level_in   = LVL_IDLE;
               end else if (walk_level_ff == LVL_2 && in_item_ff.entry_word[LARGE_BIT]) begin
                  // 1GB page: frame bits below bit 30 are ignored, so concatenate
                  result.res_kind  = RES_DONE;
                  result.phys_addr = {in_item_ff.entry_word[51:30], saved_vaddr_ff[29:0]};
                  walk_level_in    = LVL_IDLE;
               end else if (walk_level_ff == LVL_3 && in_item_ff.entry_word[LARGE_BIT]) begin
                  // 2MB page: full add, entry bits 12-20 are kept
                  result.res_kind  = RES_DONE;
                  result.phys_addr = 52'(table_addr) + {31'd0, saved_vaddr_ff[20:0]};
                  walk_level_in    = LVL_IDLE;
               end else begin
                  result.res_kind  = RES_READ;
                  result.read_addr = table_addr + {52'd0, next_idx, 3'b000};
                  case (walk_level_ff)
                     LVL_1:   walk_level_in = LVL_2;
                     LVL_2:   walk_level_in = LVL_3;
                     default: walk_level_in = LVL_4;
                  endcase
               end
            end
            LVL_4: begin
               // leaf: present bit not tested, a zero frame faults
               has_result      = 1'b1;
               result.res_kind = RES_DONE;
               walk_level_in   = LVL_IDLE;
               if (table_addr == 64'd0) begin
                  result.fault = 1'b1;
               end else begin
                  result.phys_addr = {16'd0, in_item_ff.entry_word[35:12],
                                      saved_vaddr_ff[11:0]};
               end
            end
            default: begin
               // entry while idle: drop it
               has_result = 1'b0;
            end
         endcase
      end
   end

   // Handshake: advance the input register when the queue has room or no result.
   always_comb begin
      pop       = q_valid_ff[0] && !rsp_stall;
      advance   = in_valid_ff
               && (!has_result || !(q_valid_ff[0] && q_valid_ff[1]) || pop);
      push      = advance && has_result;
      req_stall = in_valid_ff && !advance;
      accept    = req_valid && !req_stall;

      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      // shift the queue on a pop, then push into the first free slot
      q_valid_in[0] = q_valid_ff[0];
      q_valid_in[1] = q_valid_ff[1];
      q_item_in[0]  = q_item_ff[0];
      q_item_in[1]  = q_item_ff[1];
      if (pop) begin
         q_valid_in[0] = q_valid_ff[1];
         q_item_in[0]  = q_item_ff[1];
         q_valid_in[1] = 1'b0;
      end
      if (push) begin
         if (!q_valid_in[0]) begin
            q_valid_in[0] = 1'b1;
            q_item_in[0]  = result;
         end else begin
            q_valid_in[1] = 1'b1;
            q_item_in[1]  = result;
         end
      end
   end

   assign rsp_valid = q_valid_ff[0];
   assign rsp_item  = q_item_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         walk_level_ff <= LVL_IDLE;
         q_valid_ff[0] <= 1'b0;
         q_valid_ff[1] <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         q_valid_ff[0] <= q_valid_in[0];
         q_valid_ff[1] <= q_valid_in[1];
         if (advance) begin
            walk_level_ff <= walk_level_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         saved_vaddr_ff <= saved_vaddr_in;
      end
      q_item_ff[0] <= q_item_in[0];
      q_item_ff[1] <= q_item_in[1];
   end

   `ASSERT_AT(a_queue_packed, clock, reset, !q_valid_ff[1] || q_valid_ff[0])
   `ASSERT_AT(a_no_overflow, clock, reset, !(push && q_valid_ff[0] && q_valid_ff[1] && !pop))
   `ASSERT_NEXT(a_done_idles, clock, reset, push && result.res_kind == RES_DONE, walk_level_ff == LVL_IDLE)
   `ASSERT_NEXT(a_start_level1, clock, reset, advance && in_item_ff.req_type == REQ_START, walk_level_ff == LVL_1)

endmodule

`default_nettype wire

// ===== tb/sv/four_level_page_table_walker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_tb
// Drives start and table-entry items into the walker, predicts every entry
// read and every finished translation, and checks each result item in order
// under random idling, a long consumer hold-off and idle-free stretches.
// ----------------------------------------------------------------------------

module four_level_page_table_walker_tb;

   import flptw_pkg::*;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 6;
   localparam int          HOLD_LEN     = 150;
   localparam int          IDLE_PCT     = 28;
   localparam logic [63:0] GIG_MASK     = 64'h000F_FFFF_C000_0000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   // Shared test controls and counters; the controls are written with nonblocking assignments.
   logic         idle_en   = 1'b1;
   logic         hold_rsp  = 1'b0;
   int           hold_count = 0;
   int           cycle_count = 0;
   int           fail_count  = 0;
   int           items_sent  = 0;

   // Walker state as the testbench believes it to be.
   level_type    walk_lvl = LVL_IDLE;
   logic [47:0]  walk_va  = '0;

   rsp_item_type pending_walk_results[$];
   rsp_item_type walk_expect;

   four_level_page_table_walker uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor: one accepted item in, at most one result item out.
   // ------------------------------------------------------------------------
   function automatic rsp_item_type walk_read(input logic [63:0] addr);
      rsp_item_type r;
      r = '0;
      r.res_kind  = RES_READ;
      r.read_addr = addr;
      return r;
   endfunction

   // Finishing a walk always returns the walker to idle.
   function automatic rsp_item_type walk_done(input logic [63:0] pa, input logic flt);
      rsp_item_type r;
      r = '0;
      r.res_kind  = RES_DONE;
      r.phys_addr = flt ? 52'd0 : pa[51:0];
      r.fault     = flt;
      walk_lvl    = LVL_IDLE;
      return r;
   endfunction

   function automatic bit page_walk_step(input req_item_type it, output rsp_item_type r);
      logic [63:0] e;
      logic [63:0] leaf;
      logic [8:0]  idx;
      e = it.entry_word;
      r = '0;
      if (it.req_type == REQ_START) begin
         // A start always wins, even over a walk in flight.
         walk_va  = it.virt_addr;
         walk_lvl = LVL_1;
         r = walk_read((it.table_base & BASE_MASK) + {52'd0, walk_va[47:39], 3'b000});
         return 1'b1;
      end
      // Entries that arrive with no walk running are dropped.
      if (walk_lvl == LVL_IDLE)
         return 1'b0;
      leaf = e & TABLE_MASK;
      if (walk_lvl == LVL_4) begin
         // The leaf ignores the present bit; only an empty frame faults.
         if (leaf == 64'd0)
            r = walk_done(64'd0, 1'b1);
         else
            r = walk_done(leaf + {52'd0, walk_va[11:0]}, 1'b0);
         return 1'b1;
      end
      if (!e[PRESENT_BIT]) begin
         r = walk_done(64'd0, 1'b1);
         return 1'b1;
      end
      if (walk_lvl == LVL_2 && e[LARGE_BIT]) begin
         r = walk_done((e & GIG_MASK) + {34'd0, walk_va[29:0]}, 1'b0);
         return 1'b1;
      end
      if (walk_lvl == LVL_3 && e[LARGE_BIT]) begin
         // Full add: entry bits 12-20 are kept and added to the offset.
         r = walk_done(leaf + {43'd0, walk_va[20:0]}, 1'b0);
         return 1'b1;
      end
      case (walk_lvl)
         LVL_1:   idx = walk_va[38:30];
         LVL_2:   idx = walk_va[29:21];
         default: idx = walk_va[20:12];
      endcase
      r = walk_read(leaf + {52'd0, idx, 3'b000});
      walk_lvl = level_type'(walk_lvl + 3'd1);
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offer one item and hold it until taken; predict at the accepting edge.
   // Valid stays high afterwards unless an idle gap is drawn; each further
   // idle cycle is drawn again, each with IDLE_PCT chances in a hundred.
   task automatic send_item(input req_item_type it);
      rsp_item_type r;
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      if (page_walk_step(it, r))
         pending_walk_results.push_back(r);
      if (idle_en && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < IDLE_PCT)
            @(posedge clock);
      end
   endtask

   // Fields not used by the item kind carry random junk.
   task automatic send_start(input logic [63:0] base, input logic [47:0] va);
      req_item_type it;
      it.req_type   = REQ_START;
      it.table_base = base;
      it.virt_addr  = va;
      it.entry_word = rand64();
      send_item(it);
   endtask

   task automatic send_entry(input logic [63:0] e);
      req_item_type it;
      it.req_type   = REQ_ENTRY;
      it.table_base = rand64();
      it.virt_addr  = 48'(rand64());
      it.entry_word = e;
      send_item(it);
   endtask

   // Shape an entry so most walks get deep: present most of the time,
   // large pages now and then, an empty leaf once in a while.
   function automatic logic [63:0] walk_entry();
      logic [63:0] e;
      e = rand64();
      e[PRESENT_BIT] = ($urandom_range(99) >= 10);
      if (walk_lvl == LVL_2 || walk_lvl == LVL_3)
         e[LARGE_BIT] = ($urandom_range(99) < 20);
      if (walk_lvl == LVL_4 && $urandom_range(99) < 10)
         e = e & ~TABLE_MASK;
      return e;
   endfunction

   // One walk with random content; now and then cut short by the next start.
   task automatic random_walk();
      send_start(rand64(), 48'(rand64()));
      while (walk_lvl != LVL_IDLE) begin
         if ($urandom_range(99) < 4)
            break;
         send_entry(walk_entry());
      end
   endtask

   // Drop valid, let every expected result arrive, then settle.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_walk_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver side: random stalls, or a long hold-off when asked for.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_rsp && hold_count < HOLD_LEN) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         if (!hold_rsp)
            hold_count <= 0;
         rsp_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Check each accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_walk_results.size() == 0) begin
            $error("result item with nothing expected: kind %0d read %h phys %h fault %0d",
                   rsp_item.res_kind, rsp_item.read_addr, rsp_item.phys_addr,
                   rsp_item.fault);
            fail_count++;
         end else begin
            walk_expect = pending_walk_results.pop_front();
            if (rsp_item.res_kind !== walk_expect.res_kind) begin
               $error("res_kind: expected %0d, got %0d",
                      walk_expect.res_kind, rsp_item.res_kind);
               fail_count++;
            end
            if (rsp_item.read_addr !== walk_expect.read_addr) begin
               $error("read_addr: expected %h, got %h",
                      walk_expect.read_addr, rsp_item.read_addr);
               fail_count++;
            end
            if (rsp_item.phys_addr !== walk_expect.phys_addr) begin
               $error("phys_addr: expected %h, got %h",
                      walk_expect.phys_addr, rsp_item.phys_addr);
               fail_count++;
            end
            if (rsp_item.fault !== walk_expect.fault) begin
               $error("fault: expected %0d, got %0d",
                      walk_expect.fault, rsp_item.fault);
               fail_count++;
            end
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Extremes of the fields and every way a walk can end.
   task automatic test_directed();
      // All-ones base and address: the first read address wraps past 2^64.
      send_start(64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_entry(64'hFFFF_FFFF_FFFF_FFFF);       // level 1, large bit ignored
      send_entry(64'h0000_0000_1234_5001);       // level 2 table
      send_entry(64'hFFFF_FFFF_FFFF_FF01);       // level 3 table
      send_entry(64'hFFFF_FFFF_FFFF_FFFF);       // full 4KB leaf
      // Zero address, fault on the top level.
      send_start(64'd0, 48'd0);
      send_entry(64'd0);
      // Fault on level 2.
      send_start(64'h0000_0000_0000_000F, 48'h8000_0000_0000);
      send_entry(64'h1);
      send_entry(64'hFFFF_FFFF_FFFF_FFFE);
      // 1GB page from an all-ones entry.
      send_start(rand64(), 48'h5555_5555_5555);
      send_entry(64'h1);
      send_entry(64'hFFFF_FFFF_FFFF_FFFF);
      // 2MB page whose entry keeps bits 12-20 set.
      send_start(rand64(), 48'hAAAA_AAAA_AAAA);
      send_entry(64'h1);
      send_entry(64'h1);
      send_entry(64'h0000_000F_FFFF_F081);
      // Level 3 with the large bit but no present bit faults.
      send_start(rand64(), 48'h0123_4567_89AB);
      send_entry(64'h1);
      send_entry(64'h1);
      send_entry(64'h80);
      // Entry with no walk running is dropped.
      send_entry(64'hFFFF_FFFF_FFFF_FFFF);
      // Start while busy, then an empty leaf and a leaf without present bit.
      send_start(rand64(), 48'hFFFF_0000_FFFF);
      send_entry(64'h1);
      send_start(rand64(), 48'h0000_FFFF_0000);
      send_entry(64'h1);
      send_entry(64'h1);
      send_entry(64'h1);
      send_entry(64'hFFFF_FFF0_0000_0FFF);       // leaf frame zero: fault
      send_start(rand64(), 48'hFFFF_FFFF_FFFF);
      send_entry(64'h1);
      send_entry(64'h1);
      send_entry(64'h1);
      send_entry(64'h0000_0000_0000_1000);       // present clear, still maps
      wait_drain();
   endtask

   // Mostly well-formed walks with random content, stray entries now and
   // then, and the odd pause until every result is home.
   task automatic test_random_walks(input int target);
      while (items_sent < target) begin
         if ($urandom_range(99) < 5)
            send_entry(rand64());
         if ($urandom_range(99) < 3)
            wait_drain();
         random_walk();
      end
      wait_drain();
   endtask

   // Hold the consumer off for a long stretch while walks keep coming, so
   // the result queue fills and the input stalls.
   task automatic test_backpressure(input int count);
      int start_items;
      start_items = items_sent;
      hold_rsp <= 1'b1;
      while (items_sent < start_items + count)
         random_walk();
      wait_drain();
      hold_rsp <= 1'b0;
   endtask

   // Full rate on both sides.
   task automatic test_no_idle(input int count);
      int start_items;
      start_items = items_sent;
      idle_en <= 1'b0;
      @(posedge clock);
      while (items_sent < start_items + count)
         random_walk();
      wait_drain();
      idle_en <= 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure(50);
      test_random_walks(1250);
      test_no_idle(300);
      test_backpressure(40);
      wait_drain();
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/flptw_pkg.sv
sv/four_level_page_table_walker.sv
tb/sv/four_level_page_table_walker_tb.sv
